/* hdl/dfr_pkg.sv */
// ---------------------------------------------------------------------------
// dfr_pkg
// Shared constants, codes and types of the delimited frame receiver.
// ---------------------------------------------------------------------------
package dfr_pkg;

    // Frame store sizing: room for the frame, the end byte and the terminator
    localparam int FRAME_DEPTH = 32;
    localparam int STORE_DEPTH = FRAME_DEPTH + 2;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam int BYTE_W      = 8;
    localparam int CAP_W       = 16;
    localparam int STATUS_W    = 2;
    localparam int CTRL_W      = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 8;
    localparam int IN_DATA_W   = BYTE_W + CAP_W;

    typedef logic [ADDR_W-1:0] addr_t;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MANUAL_START = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MANUAL_END   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_START   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_END     = 3'd4;

    // control_mode codes
    localparam logic [CTRL_W-1:0] CTRL_IGNORE = 2'd0;
    localparam logic [CTRL_W-1:0] CTRL_MANUAL = 2'd1;
    localparam logic [CTRL_W-1:0] CTRL_AUTO   = 2'd2;

    // Input word kinds
    localparam logic IN_RX_BYTE = 1'b0;
    localparam logic IN_READ    = 1'b1;

    // Read status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FRAME = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_BIG  = 2'd2;

    typedef struct packed {
        logic [CTRL_W-1:0] control_mode;
        logic [BYTE_W-1:0] manual_start;
        logic [BYTE_W-1:0] manual_end;
        logic [BYTE_W-1:0] auto_start;
        logic [BYTE_W-1:0] auto_end;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   data;
        logic [STATUS_W-1:0] status;
        logic                last;
    } item_t;

    typedef struct packed {
        logic  push;
        item_t item;
    } push_t;

    typedef struct packed {
        logic [1:0] count;
        logic       pop;
    } fifo_level_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TERM,
        S_READ
    } ctrl_state_t;

endpackage

/* hdl/delimited_frame_receiver.sv */
// ---------------------------------------------------------------------------
// delimited_frame_receiver
// Gathers received bytes into start/end delimited frames and hands them out.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                  Carries
//  s_axis    in         s_axis_tvalid/tready       received byte or frame read
//  m_axis    out        m_axis_tvalid/tready       frame byte or read status
//  cfg       in         cfg_valid/cfg_ready        register index and data
//
//  An end byte is followed by a terminator write, as the end byte and the zero
//  terminator go through the single write port of the frame store.
//  A read that yields a status pushes it straight into the output buffer. A
//  read of a frame starts, issues one store read per byte while the buffer has
//  room, and the last read then lands in the output buffer.
//  Reset clears the control state only; the frame store has no clearing pass
//  and every byte a read returns was written before it.
//  Stalls: a two-word output buffer decouples the output; store reads are
//  issued only when the buffer has room, so m_axis_tready may drop anywhere.
//
module delimited_frame_receiver (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input words
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [dfr_pkg::IN_DATA_W-1:0]       s_axis_tdata,   // rx_byte[7:0], read_capacity[23:8]
    input  logic                                s_axis_tuser,   // mode[0]
    // Result words
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [dfr_pkg::BYTE_W-1:0]          m_axis_tdata,   // out_byte[7:0]
    output logic [dfr_pkg::STATUS_W-1:0]        m_axis_tuser,   // read_status[1:0]
    output logic                                m_axis_tlast,
    // Configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dfr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dfr_pkg::CFG_DATA_W-1:0]      cfg_data
);

    dfr_pkg::cfg_t              cfg;
    dfr_pkg::fifo_level_t       level;
    dfr_pkg::push_t             push;
    dfr_pkg::item_t             head;
    logic                       mem_we;
    dfr_pkg::addr_t             mem_waddr;
    logic [dfr_pkg::BYTE_W-1:0] mem_wdata;
    logic                       mem_re;
    dfr_pkg::addr_t             mem_raddr;
    logic [dfr_pkg::BYTE_W-1:0] mem_rdata;

    // Delimiter and mode registers
    dfr_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Assembly and read sequencing; owns every access to the store
    dfr_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_mode     (s_axis_tuser),
        .in_rx_byte  (s_axis_tdata[dfr_pkg::BYTE_W-1:0]),
        .in_capacity (s_axis_tdata[dfr_pkg::IN_DATA_W-1:dfr_pkg::BYTE_W]),
        .level       (level),
        .push        (push),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    // Frame store: frame bytes, end byte and terminator
    dfr_ram #(
        .WIDTH (dfr_pkg::BYTE_W),
        .DEPTH (dfr_pkg::STORE_DEPTH)
    ) u_frame_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Hold results until the output side takes them
    dfr_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .head      (head),
        .level     (level)
    );

    assign m_axis_tdata = head.data;
    assign m_axis_tuser = head.status;
    assign m_axis_tlast = head.last;

endmodule

/* hdl/dfr_ram.sv */
// ---------------------------------------------------------------------------
// dfr_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module dfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 34
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hdl/dfr_cfg_regs.sv */
// ---------------------------------------------------------------------------
// dfr_cfg_regs
// Configuration register file written over the configuration channel.
// ---------------------------------------------------------------------------
module dfr_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dfr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dfr_pkg::CFG_DATA_W-1:0]   cfg_data,
    output dfr_pkg::cfg_t                    cfg
);

    dfr_pkg::cfg_t cfg_reg;
    dfr_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                dfr_pkg::REG_CONTROL_MODE: cfg_next.control_mode = cfg_data[dfr_pkg::CTRL_W-1:0];
                dfr_pkg::REG_MANUAL_START: cfg_next.manual_start = cfg_data;
                dfr_pkg::REG_MANUAL_END:   cfg_next.manual_end   = cfg_data;
                dfr_pkg::REG_AUTO_START:   cfg_next.auto_start   = cfg_data;
                dfr_pkg::REG_AUTO_END:     cfg_next.auto_end     = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* hdl/dfr_out_fifo.sv */
// ---------------------------------------------------------------------------
// dfr_out_fifo
// Two-entry result buffer between the frame reader and the output channel.
// ---------------------------------------------------------------------------
module dfr_out_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dfr_pkg::push_t        push,
    input  logic                  out_ready,
    output logic                  out_valid,
    output dfr_pkg::item_t        head,
    output dfr_pkg::fifo_level_t  level
);

    dfr_pkg::item_t slot_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           pop;

    assign out_valid   = (count_reg != 2'd0);
    assign pop         = out_valid && out_ready;
    assign head        = slot_reg[rd_ptr_reg];
    assign level.count = count_reg;
    assign level.pop   = pop;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push.push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push.push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.push)
        begin
            slot_reg[wr_ptr_reg] <= push.item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* hdl/dfr_ctrl.sv */
// ---------------------------------------------------------------------------
// dfr_ctrl
// Frame assembly and read sequencing around the frame store.
// ---------------------------------------------------------------------------
module dfr_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dfr_pkg::cfg_t                cfg,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         in_mode,
    input  logic [dfr_pkg::BYTE_W-1:0]   in_rx_byte,
    input  logic [dfr_pkg::CAP_W-1:0]    in_capacity,
    input  dfr_pkg::fifo_level_t         level,
    output dfr_pkg::push_t               push,
    output logic                         mem_we,
    output dfr_pkg::addr_t               mem_waddr,
    output logic [dfr_pkg::BYTE_W-1:0]   mem_wdata,
    output logic                         mem_re,
    output dfr_pkg::addr_t               mem_raddr,
    input  logic [dfr_pkg::BYTE_W-1:0]   mem_rdata
);

    dfr_pkg::ctrl_state_t state_reg, state_next;
    dfr_pkg::addr_t       fill_count_reg, fill_count_next;
    logic                 frame_open_reg, frame_open_next;
    logic                 frame_ready_reg, frame_ready_next;
    dfr_pkg::addr_t       ready_length_reg, ready_length_next;
    dfr_pkg::addr_t       rd_idx_reg, rd_idx_next;
    logic                 pending_reg, pending_next;
    logic                 pending_last_reg, pending_last_next;

    logic                       active;
    logic [dfr_pkg::BYTE_W-1:0] start_byte;
    logic [dfr_pkg::BYTE_W-1:0] end_byte;
    logic                       accept;
    logic [2:0]                 occupancy;
    logic                       room;
    logic                       final_read;

    always_comb
    begin
        case (cfg.control_mode)
            dfr_pkg::CTRL_MANUAL:
            begin
                active     = 1'b1;
                start_byte = cfg.manual_start;
                end_byte   = cfg.manual_end;
            end
            dfr_pkg::CTRL_AUTO:
            begin
                active     = 1'b1;
                start_byte = cfg.auto_start;
                end_byte   = cfg.auto_end;
            end
            default:
            begin
                active     = 1'b0;
                start_byte = cfg.manual_start;
                end_byte   = cfg.manual_end;
            end
        endcase
    end

    assign in_ready   = (state_reg == dfr_pkg::S_IDLE) && !pending_reg && (level.count < 2'd2);
    assign accept     = in_valid && in_ready;
    // Words in the buffer plus the one on its way from the store
    assign occupancy  = 3'(level.count) + 3'(pending_reg) - 3'(level.pop);
    assign room       = (occupancy < 3'd2);
    assign final_read = (rd_idx_reg == dfr_pkg::addr_t'(ready_length_reg - 1'b1));

    always_comb
    begin
        state_next        = state_reg;
        fill_count_next   = fill_count_reg;
        frame_open_next   = frame_open_reg;
        frame_ready_next  = frame_ready_reg;
        ready_length_next = ready_length_reg;
        rd_idx_next       = rd_idx_reg;
        pending_next      = 1'b0;
        pending_last_next = 1'b0;

        mem_we    = 1'b0;
        mem_waddr = fill_count_reg;
        mem_wdata = in_rx_byte;
        mem_re    = 1'b0;
        mem_raddr = rd_idx_reg;

        // Store data from the previous cycle's read lands in the buffer
        push.push        = pending_reg;
        push.item.data   = mem_rdata;
        push.item.status = dfr_pkg::ST_OK;
        push.item.last   = pending_last_reg;

        case (state_reg)
            dfr_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (in_mode == dfr_pkg::IN_RX_BYTE)
                    begin
                        if (active)
                        begin
                            if (in_rx_byte == start_byte)
                            begin
                                mem_we           = 1'b1;
                                mem_waddr        = '0;
                                fill_count_next  = dfr_pkg::addr_t'(1);
                                frame_open_next  = 1'b1;
                                frame_ready_next = 1'b0;
                            end
                            else if (in_rx_byte == end_byte)
                            begin
                                // End byte goes in now, the terminator next cycle
                                mem_we            = 1'b1;
                                ready_length_next = dfr_pkg::addr_t'(fill_count_reg
                                                    + dfr_pkg::addr_t'(2));
                                frame_ready_next  = 1'b1;
                                fill_count_next   = '0;
                                frame_open_next   = 1'b0;
                                state_next        = dfr_pkg::S_TERM;
                            end
                            else if (frame_open_reg)
                            begin
                                if (fill_count_reg < dfr_pkg::addr_t'(dfr_pkg::FRAME_DEPTH - 1))
                                begin
                                    mem_we          = 1'b1;
                                    fill_count_next = dfr_pkg::addr_t'(fill_count_reg + 1'b1);
                                end
                                else
                                begin
                                    // Overlong frame: drop it
                                    fill_count_next = '0;
                                    frame_open_next = 1'b0;
                                end
                            end
                        end
                    end
                    else
                    begin
                        if (!frame_ready_reg)
                        begin
                            push.push        = 1'b1;
                            push.item.data   = '0;
                            push.item.status = dfr_pkg::ST_NO_FRAME;
                            push.item.last   = 1'b1;
                        end
                        else
                        begin
                            frame_ready_next = 1'b0;
                            if (dfr_pkg::CAP_W'(ready_length_reg) > in_capacity)
                            begin
                                push.push        = 1'b1;
                                push.item.data   = '0;
                                push.item.status = dfr_pkg::ST_TOO_BIG;
                                push.item.last   = 1'b1;
                            end
                            else
                            begin
                                rd_idx_next = '0;
                                state_next  = dfr_pkg::S_READ;
                            end
                        end
                    end
                end
            end
            dfr_pkg::S_TERM:
            begin
                mem_we     = 1'b1;
                mem_waddr  = dfr_pkg::addr_t'(ready_length_reg - 1'b1);
                mem_wdata  = '0;
                state_next = dfr_pkg::S_IDLE;
            end
            dfr_pkg::S_READ:
            begin
                if (room)
                begin
                    mem_re            = 1'b1;
                    pending_next      = 1'b1;
                    pending_last_next = final_read;
                    rd_idx_next       = dfr_pkg::addr_t'(rd_idx_reg + 1'b1);
                    if (final_read)
                    begin
                        state_next = dfr_pkg::S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = dfr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= dfr_pkg::S_IDLE;
            fill_count_reg   <= '0;
            frame_open_reg   <= 1'b0;
            frame_ready_reg  <= 1'b0;
            ready_length_reg <= '0;
            rd_idx_reg       <= '0;
            pending_reg      <= 1'b0;
            pending_last_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            fill_count_reg   <= fill_count_next;
            frame_open_reg   <= frame_open_next;
            frame_ready_reg  <= frame_ready_next;
            ready_length_reg <= ready_length_next;
            rd_idx_reg       <= rd_idx_next;
            pending_reg      <= pending_next;
            pending_last_reg <= pending_last_next;
        end
    end

endmodule

/* hdl/dfr_checker.sv */
// ---------------------------------------------------------------------------
// dfr_port_checks
// Port-level checks of the delimited frame receiver, bound to the top level.
// ---------------------------------------------------------------------------
module dfr_port_checks (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tready,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [dfr_pkg::BYTE_W-1:0]          m_axis_tdata,
    input  logic [dfr_pkg::STATUS_W-1:0]        m_axis_tuser,
    input  logic                                m_axis_tlast
);

    // A stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled result word changed");

    // Status words stand alone: zero byte and last mark
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != dfr_pkg::ST_OK) |->
            (m_axis_tdata == '0) && m_axis_tlast)
        else $error("status word without zero byte or last mark");

    // Only frame bytes continue a read
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> (m_axis_tuser == dfr_pkg::ST_OK))
        else $error("non-final word with error status");

    // No new input word while a frame is still being handed out
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input accepted in the middle of a frame read");

endmodule

bind delimited_frame_receiver dfr_port_checks u_dfr_port_checks (.*);

/* sim/dfr_checker.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// dfr_checker
// Predicts the result words of the frame receiver from the words it accepts
// and compares them, field by field, with the words it hands out.
// ---------------------------------------------------------------------------
module dfr_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [dfr_pkg::IN_DATA_W-1:0]       s_axis_tdata,   // rx_byte[7:0], read_capacity[23:8]
    input  logic                                s_axis_tuser,   // mode[0]
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [dfr_pkg::BYTE_W-1:0]          m_axis_tdata,   // out_byte[7:0]
    input  logic [dfr_pkg::STATUS_W-1:0]        m_axis_tuser,   // read_status[1:0]
    input  logic                                m_axis_tlast,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [dfr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dfr_pkg::CFG_DATA_W-1:0]      cfg_data,
    output int                                  fail_count,
    output int                                  words_owed
);
    import dfr_pkg::*;

    // Register copies
    logic [CTRL_W-1:0] ctrl_mode  = CTRL_IGNORE;
    logic [BYTE_W-1:0] man_start  = '0;
    logic [BYTE_W-1:0] man_end    = '0;
    logic [BYTE_W-1:0] adr_start  = '0;
    logic [BYTE_W-1:0] adr_end    = '0;

    // Frame assembly state
    logic [BYTE_W-1:0] byte_copy [STORE_DEPTH];
    logic [5:0]        fill         = '0;
    logic              assembling   = 1'b0;
    logic              complete     = 1'b0;
    logic [5:0]        complete_len = '0;

    int fail_total = 0;
    int owed_total = 0;

    item_t frame_words_due [$];

    assign fail_count = fail_total;
    assign words_owed = owed_total;

    function automatic item_t make_item(input logic [BYTE_W-1:0] data,
                                        input logic [STATUS_W-1:0] status,
                                        input logic last);
        item_t it;
        it.data   = data;
        it.status = status;
        it.last   = last;
        return it;
    endfunction

    task automatic absorb_byte(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] sb;
        logic [BYTE_W-1:0] eb;
        if (ctrl_mode == CTRL_MANUAL)
        begin
            sb = man_start;
            eb = man_end;
        end
        else if (ctrl_mode == CTRL_AUTO)
        begin
            sb = adr_start;
            eb = adr_end;
        end
        else
        begin
            return;
        end
        // A byte matching both delimiters opens a frame
        if (b == sb)
        begin
            byte_copy[0] = b;
            fill       = 6'd1;
            assembling = 1'b1;
            complete   = 1'b0;
        end
        else if (b == eb)
        begin
            byte_copy[fill]        = b;
            byte_copy[fill + 6'd1] = 8'h00;
            complete_len = fill + 6'd2;
            complete     = 1'b1;
            fill         = '0;
            assembling   = 1'b0;
        end
        else if (assembling)
        begin
            if (fill < FRAME_DEPTH - 1)
            begin
                byte_copy[fill] = b;
                fill = fill + 6'd1;
            end
            else
            begin
                // overgrown frame: drop it
                fill       = '0;
                assembling = 1'b0;
            end
        end
    endtask

    task automatic hand_out_frame(input logic [CAP_W-1:0] cap);
        int n;
        int k;
        if (!complete)
        begin
            frame_words_due.push_back(make_item('0, ST_NO_FRAME, 1'b1));
            return;
        end
        complete = 1'b0;
        n = complete_len;
        if (n > int'(cap) || n == 0 || n > STORE_DEPTH)
        begin
            frame_words_due.push_back(make_item('0, (n > int'(cap)) ? ST_TOO_BIG : ST_NO_FRAME,
                                                1'b1));
        end
        else
        begin
            for (k = 0; k < n; k++)
            begin
                frame_words_due.push_back(make_item(byte_copy[k], ST_OK, k == n - 1));
            end
        end
    endtask

    task automatic check_word();
        item_t want;
        if (frame_words_due.size() == 0)
        begin
            $error("unexpected word: out_byte %0h read_status %0d last %0b",
                   m_axis_tdata, m_axis_tuser, m_axis_tlast);
            fail_total++;
            return;
        end
        want = frame_words_due.pop_front();
        if (m_axis_tdata !== want.data)
        begin
            $error("out_byte: expected %0h, got %0h", want.data, m_axis_tdata);
            fail_total++;
        end
        if (m_axis_tuser !== want.status)
        begin
            $error("read_status: expected %0d, got %0d", want.status, m_axis_tuser);
            fail_total++;
        end
        if (m_axis_tlast !== want.last)
        begin
            $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
            fail_total++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_CONTROL_MODE: ctrl_mode = cfg_data[CTRL_W-1:0];
                    REG_MANUAL_START: man_start = cfg_data;
                    REG_MANUAL_END:   man_end   = cfg_data;
                    REG_AUTO_START:   adr_start = cfg_data;
                    REG_AUTO_END:     adr_end   = cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser == IN_READ)
                begin
                    hand_out_frame(s_axis_tdata[BYTE_W +: CAP_W]);
                end
                else
                begin
                    absorb_byte(s_axis_tdata[BYTE_W-1:0]);
                end
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                check_word();
            end
            owed_total <= frame_words_due.size();
        end
    end

endmodule

/* sim/tb_delimited_frame_receiver.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_delimited_frame_receiver
// Drives received bytes, frame reads and register writes into the frame
// receiver; a checker beside it predicts and compares every result word.
// ---------------------------------------------------------------------------
module tb_delimited_frame_receiver;
    import dfr_pkg::*;

    // control_mode value with no meaning; the block must ignore bytes in it
    localparam logic [CTRL_W-1:0] CTRL_UNUSED = 2'd3;

    localparam int LONG_HOLD    = 400;   // receiver hold-off, long enough to back up the input
    localparam int SETTLE       = 8;     // end byte and its terminator write give no result; allow margin
    localparam int STALL_LIMIT  = 2000;  // cycles without any word moving before giving up
    localparam int ITEM_TARGET  = 150;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata;   // rx_byte[7:0], read_capacity[23:8]
    logic                   s_axis_tuser;   // mode[0]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [BYTE_W-1:0]      m_axis_tdata;   // out_byte[7:0]
    logic [STATUS_W-1:0]    m_axis_tuser;   // read_status[1:0]
    logic                   m_axis_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int   fail_count;
    int   words_owed;
    int   counted_items;
    int   hold_off_asks = 0;  // raised by the stimulus
    int   hold_off_done = 0;  // advanced by the result sink once a hold-off is served
    bit   quiet_tx      = 1'b0;   // sender runs without gaps
    bit   quiet_rx      = 1'b0;   // receiver runs without stalls
    cfg_t cur_cfg;

    delimited_frame_receiver i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    dfr_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .words_owed    (words_owed)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Delimiters currently in force, as seen by the stimulus; the manual pair
    // stands in while the block ignores bytes
    function automatic logic [BYTE_W-1:0] start_byte();
        return (cur_cfg.control_mode == CTRL_AUTO) ? cur_cfg.auto_start : cur_cfg.manual_start;
    endfunction

    function automatic logic [BYTE_W-1:0] end_byte();
        return (cur_cfg.control_mode == CTRL_AUTO) ? cur_cfg.auto_end : cur_cfg.manual_end;
    endfunction

    function automatic logic [CAP_W-1:0] any_cap();
        return CAP_W'($urandom_range(0, 65535));
    endfunction

    // Offer one input word and hold it until taken. valid stays high into the
    // next word when no gap is drawn, so it is never lowered and raised in one step.
    task automatic send_word(input logic kind, input logic [BYTE_W-1:0] b,
                             input logic [CAP_W-1:0] cap);
        int gap;
        gap = quiet_tx ? 0 : $urandom_range(0, 14);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {cap, b};
        s_axis_tuser  <= kind;
        do @(posedge clk); while (!s_axis_tready);
        counted_items++;
    endtask

    task automatic read_frame(input logic [CAP_W-1:0] cap);
        send_word(IN_READ, BYTE_W'($urandom_range(0, 255)), cap);
    endtask

    // Stop offering, wait for every owed word, then let the block settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (words_owed != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // One register write; the caller lowers valid after the last of a batch
    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Write all five registers; call only with the block drained
    task automatic program_regs(input cfg_t c);
        put_reg(REG_CONTROL_MODE, CFG_DATA_W'(c.control_mode));
        put_reg(REG_MANUAL_START, c.manual_start);
        put_reg(REG_MANUAL_END,   c.manual_end);
        put_reg(REG_AUTO_START,   c.auto_start);
        put_reg(REG_AUTO_END,     c.auto_end);
        cfg_valid <= 1'b0;
        cur_cfg = c;
    endtask

    // Settings for one phase: fixed extremes first, random after that
    function automatic cfg_t pick_cfg(input int phase);
        cfg_t c;
        int   pick;
        c.manual_start = BYTE_W'($urandom_range(0, 255));
        c.manual_end   = BYTE_W'($urandom_range(0, 255));
        c.auto_start   = BYTE_W'($urandom_range(0, 255));
        c.auto_end     = BYTE_W'($urandom_range(0, 255));
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            c.control_mode = CTRL_IGNORE;
        end
        else if (pick == 1)
        begin
            c.control_mode = CTRL_UNUSED;
        end
        else
        begin
            c.control_mode = (pick < 6) ? CTRL_MANUAL : CTRL_AUTO;
        end
        case (phase)
            1:
            begin
                c.control_mode = CTRL_MANUAL;
                c.manual_start = 8'h00;
                c.manual_end   = 8'hFF;
            end
            2:
            begin
                c.control_mode = CTRL_AUTO;
                c.auto_start   = 8'hFF;
                c.auto_end     = 8'h00;
            end
            3: c.control_mode = CTRL_IGNORE;
            4: c.control_mode = CTRL_UNUSED;
            5:
            begin
                c.control_mode = CTRL_MANUAL;
                c.manual_end   = c.manual_start;
            end
            default: ;
        endcase
        return c;
    endfunction

    // Start byte, body, optional end byte and optional read. Body bytes mostly
    // avoid the delimiters; long bodies overgrow the store and drop the frame.
    task automatic send_frame(input int body_len, input bit close_it, input bit read_it);
        logic [BYTE_W-1:0] sb;
        logic [BYTE_W-1:0] eb;
        logic [BYTE_W-1:0] b;
        logic [CAP_W-1:0]  cap;
        int                n;
        int                i;
        sb = start_byte();
        eb = end_byte();
        send_word(IN_RX_BYTE, sb, any_cap());
        for (i = 0; i < body_len; i++)
        begin
            b = BYTE_W'($urandom_range(0, 255));
            if ($urandom_range(0, 15) != 0)
            begin
                while (b == sb || b == eb) b = BYTE_W'($urandom_range(0, 255));
            end
            send_word(IN_RX_BYTE, b, any_cap());
        end
        if (close_it)
        begin
            send_word(IN_RX_BYTE, eb, any_cap());
        end
        if (read_it)
        begin
            // length of the frame as stored: start, body, end, terminator
            n = (body_len <= FRAME_DEPTH - 2) ? body_len + 3 : 2;
            case ($urandom_range(0, 6))
                0, 1:    cap = CAP_W'(n);
                2:       cap = CAP_W'(n - 1);
                3:       cap = CAP_W'($urandom_range(0, 40));
                4:       cap = '1;
                5:       cap = '0;
                default: cap = any_cap();
            endcase
            read_frame(cap);
        end
    endtask

    // Result sink: per word taken, draw a stall; honour a long hold-off on request
    initial
    begin : result_sink
        int gap;
        int taken;
        m_axis_tready = 1'b0;
        taken = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_off_asks != hold_off_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                m_axis_tready <= 1'b1;
                hold_off_done = hold_off_asks;
            end
            else if (!m_axis_tready)
            begin
                m_axis_tready <= 1'b1;
            end
            else if (m_axis_tvalid)
            begin
                taken++;
                if (taken % 32 == 0)
                begin
                    quiet_rx = ($urandom_range(0, 2) == 0);
                end
                gap = quiet_rx ? 0 : $urandom_range(0, 14);
                if (gap != 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (gap - 1) @(posedge clk);
                end
            end
        end
    end

    // Watchdog: give up when no word moves on any channel for too long
    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
            begin
                idle = 0;
            end
            else
            begin
                idle++;
            end
        end
        $display("tb_delimited_frame_receiver: errors");
        $finish;
    end

    initial
    begin : stimulus
        cfg_t c;
        int   phase;
        int   len;
        int   act;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = IN_RX_BYTE;
        cfg_valid     = 1'b0;
        cfg_index     = REG_CONTROL_MODE;
        cfg_data      = '0;
        counted_items = 0;
        cur_cfg       = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- Directed part ------------------------------------------------
        // Nothing assembled yet: read must report no frame, even at capacity zero
        read_frame('0);
        drain();

        c.control_mode = CTRL_MANUAL;
        c.manual_start = 8'h00;
        c.manual_end   = 8'hFF;
        c.auto_start   = 8'hAA;
        c.auto_end     = 8'h55;
        program_regs(c);

        // End byte with no open frame still makes a two-byte frame
        send_word(IN_RX_BYTE, 8'hFF, '0);
        read_frame(16'd1);                  // one short of the length: too big
        read_frame('1);                     // ready mark gone: no frame
        // Frame read at exactly its own length
        send_word(IN_RX_BYTE, 8'h00, '1);
        send_word(IN_RX_BYTE, 8'h12, '0);
        send_word(IN_RX_BYTE, 8'hFF, '1);
        read_frame(16'd4);
        // Stray body byte, then a start byte that restarts an open frame
        send_word(IN_RX_BYTE, 8'h33, '0);
        send_word(IN_RX_BYTE, 8'h00, '0);
        send_word(IN_RX_BYTE, 8'h80, '1);
        send_word(IN_RX_BYTE, 8'h00, '0);
        send_word(IN_RX_BYTE, 8'h7F, '1);
        send_word(IN_RX_BYTE, 8'hFF, '0);
        read_frame('1);
        // A start byte clears a frame that was waiting to be read
        send_word(IN_RX_BYTE, 8'hFF, '0);
        send_word(IN_RX_BYTE, 8'h00, '1);
        read_frame('1);
        drain();

        // Same byte as both delimiters: it only ever opens a frame
        c.control_mode = CTRL_AUTO;
        c.auto_start   = 8'h5A;
        c.auto_end     = 8'h5A;
        program_regs(c);
        send_word(IN_RX_BYTE, 8'h5A, '0);
        send_word(IN_RX_BYTE, 8'h11, '0);
        send_word(IN_RX_BYTE, 8'h5A, '1);
        read_frame('1);

        // ---- Random part --------------------------------------------------
        phase = 0;
        while (counted_items < ITEM_TARGET)
        begin
            phase++;
            drain();
            program_regs(pick_cfg(phase));

            if (phase == 1)
            begin
                // Hold the receiver off while frames keep coming back to back,
                // so the output buffer fills and the input stalls
                hold_off_asks++;
                quiet_tx = 1'b1;
                repeat (4) send_frame($urandom_range(2, 8), 1'b1, 1'b1);
                drain();
            end

            for (act = 0; act < 4 && counted_items < ITEM_TARGET; act++)
            begin
                quiet_tx = ($urandom_range(0, 3) == 0);
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(0, FRAME_DEPTH + 1)
                                                  : $urandom_range(0, 8);
                case ($urandom_range(0, 10))
                    0, 1, 2, 3, 4, 5: send_frame(len, 1'b1, 1'b1);
                    6: send_frame(len, 1'b0, 1'($urandom_range(0, 1)));   // never closed
                    7: repeat ($urandom_range(1, 4))
                           send_word(IN_RX_BYTE, BYTE_W'($urandom_range(0, 255)), any_cap());
                    8: read_frame(any_cap());
                    9:
                    begin
                        // lone end byte then read
                        send_word(IN_RX_BYTE, end_byte(), any_cap());
                        read_frame(CAP_W'($urandom_range(0, 3)));
                    end
                    default: drain();   // sender pauses until all owed words are out
                endcase
            end
        end

        drain();
        repeat (SETTLE * 2) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("tb_delimited_frame_receiver: clean");
        end
        else
        begin
            $display("tb_delimited_frame_receiver: errors");
        end
        $finish;
    end

endmodule
